### sv/rdke_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdke_pkg
// Shared types and constants for the rotary dial key encoder: held table
// sizing, key actions, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package rdke_pkg;

  // Held key table
  localparam int HELD_DEPTH = 8;
  localparam int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int FILL_W     = $clog2(HELD_DEPTH + 1);

  // Field widths
  localparam int PULSE_W = 5;
  localparam int KEY_W   = 14;
  localparam int COUNT_W = 4;
  localparam int LZ_W    = 4;

  // Dial codes and limits
  localparam logic [PULSE_W-1:0] PULSE_DIGIT_MAX = 5'd10;
  localparam logic [PULSE_W-1:0] PULSE_OPT_NUM   = 5'd18;  // option 1
  localparam logic [PULSE_W-1:0] PULSE_OPT_CODE  = 5'd17;  // option 2
  localparam logic [KEY_W-1:0]   ASCII_ZERO      = 14'd48;
  localparam int                 VALUE_MAX       = 9999;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 4'd15;

  typedef enum logic [1:0] {
    ACT_TYPE        = 2'd0,
    ACT_PRESS       = 2'd1,
    ACT_RELEASE     = 2'd2,
    ACT_RELEASE_ALL = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KSEL_ASCII,
    KSEL_ACC,
    KSEL_HELD,
    KSEL_ZERO
  } key_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_NUM,
    S_RA_LEAVE,
    S_RA_ENTER,
    S_ACCUM,
    S_JUDGE,
    S_SEARCH,
    S_DECIDE,
    S_REL_MATCH,
    S_TYPE,
    S_WALK,
    S_PRESS
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     emit;
    action_t  emit_act;
    key_sel_t emit_key;
    logic     emit_last;
    logic     set_num_mode;
    logic     enter_code;
    logic     accum;
    logic     latch_lz;
    logic     clear_seq;
    logic     ptr_zero;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     ptr_top;
    logic     remove;
    logic     append;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_opt_num;
    logic is_opt_code;
    logic code_mode;
    logic stuck;
    logic overflow;
    logic below_min;
    logic fill_zero;
    logic fill_full;
    logic ptr_at_last;
    logic match;
    logic mark_at_ptr;
    logic marks_below;
    logic marks_any;
    logic lz_zero;
    logic lz_hold;
    logic emit_ok;
  } status_t;

endpackage

### sv/rdke_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdke_ctrl
// Sequencer: decodes each dial turn, steps the code-mode judgment, walks the
// held table and paces result transfers against the output register.
// ----------------------------------------------------------------------------
module rdke_ctrl
  import rdke_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (st.is_digit) begin
          if (!st.code_mode)  state_nxt = S_NUM;
          else if (st.stuck)  state_nxt = S_IDLE;
          else                state_nxt = S_ACCUM;
        end else if (st.is_opt_num) begin
          state_nxt = st.code_mode ? S_RA_LEAVE : S_IDLE;
        end else if (st.is_opt_code) begin
          state_nxt = st.code_mode ? S_RA_LEAVE : S_RA_ENTER;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_NUM: begin
        if (st.emit_ok) state_nxt = S_IDLE;
      end
      S_RA_LEAVE: begin
        if (st.emit_ok) state_nxt = st.is_opt_num ? S_IDLE : S_RA_ENTER;
      end
      S_RA_ENTER: begin
        if (st.emit_ok) state_nxt = S_IDLE;
      end
      S_ACCUM: begin
        state_nxt = st.overflow ? S_IDLE : S_JUDGE;
      end
      S_JUDGE: begin
        if (st.below_min)      state_nxt = S_IDLE;
        else if (st.fill_zero) state_nxt = S_DECIDE;
        else                   state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (st.match)            state_nxt = S_REL_MATCH;
        else if (st.ptr_at_last) state_nxt = S_DECIDE;
      end
      S_REL_MATCH: begin
        if (st.emit_ok) state_nxt = S_IDLE;
      end
      S_DECIDE: begin
        if (st.lz_zero)                     state_nxt = S_TYPE;
        else if (st.lz_hold && !st.fill_full) state_nxt = S_PRESS;
        else                                state_nxt = S_IDLE;
      end
      S_TYPE: begin
        if (st.emit_ok) state_nxt = st.marks_any ? S_WALK : S_IDLE;
      end
      S_WALK: begin
        // leave after the lowest short hold has been released
        if (st.mark_at_ptr) begin
          if (st.emit_ok && !st.marks_below) state_nxt = S_IDLE;
        end
      end
      S_PRESS: begin
        if (st.emit_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECODE: ;
      S_NUM: begin
        cmd.emit      = 1'b1;
        cmd.emit_act  = ACT_TYPE;
        cmd.emit_key  = KSEL_ASCII;
        cmd.emit_last = 1'b1;
      end
      S_RA_LEAVE: begin
        cmd.emit         = 1'b1;
        cmd.emit_act     = ACT_RELEASE_ALL;
        cmd.emit_key     = KSEL_ZERO;
        cmd.emit_last    = st.is_opt_num;
        cmd.set_num_mode = st.emit_ok && st.is_opt_num;
      end
      S_RA_ENTER: begin
        cmd.emit       = 1'b1;
        cmd.emit_act   = ACT_RELEASE_ALL;
        cmd.emit_key   = KSEL_ZERO;
        cmd.emit_last  = 1'b1;
        cmd.enter_code = st.emit_ok;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
      end
      S_JUDGE: begin
        cmd.latch_lz = 1'b1;
        cmd.ptr_zero = 1'b1;
      end
      S_SEARCH: begin
        cmd.ptr_inc = !st.match && !st.ptr_at_last;
      end
      S_REL_MATCH: begin
        cmd.emit      = 1'b1;
        cmd.emit_act  = ACT_RELEASE;
        cmd.emit_key  = KSEL_ACC;
        cmd.emit_last = 1'b1;
        cmd.remove    = st.emit_ok;
        cmd.clear_seq = st.emit_ok;
      end
      S_DECIDE: begin
        // a hold with the table full is dropped but still ends the sequence
        cmd.clear_seq = st.lz_hold && !st.lz_zero && st.fill_full;
      end
      S_TYPE: begin
        cmd.emit      = 1'b1;
        cmd.emit_act  = ACT_TYPE;
        cmd.emit_key  = KSEL_ACC;
        cmd.emit_last = !st.marks_any;
        cmd.clear_seq = st.emit_ok;
        cmd.ptr_top   = st.emit_ok;
      end
      S_WALK: begin
        if (st.mark_at_ptr) begin
          cmd.emit      = 1'b1;
          cmd.emit_act  = ACT_RELEASE;
          cmd.emit_key  = KSEL_HELD;
          cmd.emit_last = !st.marks_below;
          cmd.remove    = st.emit_ok;
          cmd.ptr_dec   = st.emit_ok && st.marks_below;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      S_PRESS: begin
        cmd.emit      = 1'b1;
        cmd.emit_act  = ACT_PRESS;
        cmd.emit_key  = KSEL_ACC;
        cmd.emit_last = 1'b1;
        cmd.append    = st.emit_ok;
        cmd.clear_seq = st.emit_ok;
      end
      default: ;
    endcase
  end

endmodule

### sv/rdke_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdke_dpath
// Datapath: input register, mode and sequence state, held key table with
// shift-down removal, walk pointer and the result output register.
// ----------------------------------------------------------------------------
module rdke_dpath
  import rdke_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [PULSE_W-1:0] in_pulse_count,
  input  cmd_t               cmd,
  output status_t            st,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_action,
  output logic [KEY_W-1:0]   out_key,
  output logic               out_last
);

  // Minimum digit count for a value (leading zeros included)
  function automatic logic [2:0] min_count(input logic [KEY_W-1:0] v);
    logic [2:0] mc;
    if (v <= 14'd2)       mc = 3'd6;
    else if (v < 14'd10)  mc = 3'd2;
    else if (v <= 14'd25) mc = 3'd3;
    else if (v < 14'd100) mc = 3'd2;
    else                  mc = 3'd3;
    return mc;
  endfunction

  logic [PULSE_W-1:0] pulse_r;
  logic               code_mode_r;
  logic               stuck_r;
  logic [COUNT_W-1:0] count_r;
  logic [KEY_W-1:0]   acc_r;
  logic [FILL_W-1:0]  fill_r;
  logic [IDX_W-1:0]   ptr_r;
  logic [LZ_W-1:0]    lz_r;
  logic [KEY_W-1:0]   held_val_r [HELD_DEPTH];
  logic [HELD_DEPTH-1:0] held_mark_r;

  logic               out_valid_r;
  logic [1:0]         out_action_r;
  logic [KEY_W-1:0]   out_key_r;
  logic               out_last_r;

  logic [3:0]         digit;
  logic [KEY_W+3:0]   next_val;
  logic [2:0]         mc;
  logic [HELD_DEPTH-1:0] below_mask;
  logic [HELD_DEPTH-1:0] fill_mask;
  logic [KEY_W-1:0]   held_at_ptr;
  logic [KEY_W-1:0]   emit_key;
  logic               emit_ok;

  // Digit decode and value build (acc * 10 + digit)
  assign digit    = (pulse_r == PULSE_DIGIT_MAX) ? 4'd0 : pulse_r[3:0];
  assign next_val = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + (KEY_W+4)'(digit);
  assign mc       = min_count(acc_r);

  assign held_at_ptr = held_val_r[ptr_r];

  always_comb begin
    for (int k = 0; k < HELD_DEPTH; k++) begin
      below_mask[k] = (k < int'(ptr_r));
      fill_mask[k]  = (k < int'(fill_r));
    end
  end

  assign emit_ok = !out_valid_r || out_ready;

  // Status to controller
  always_comb begin
    st             = '0;
    st.is_digit    = (pulse_r != '0) && (pulse_r <= PULSE_DIGIT_MAX);
    st.is_opt_num  = (pulse_r == PULSE_OPT_NUM);
    st.is_opt_code = (pulse_r == PULSE_OPT_CODE);
    st.code_mode   = code_mode_r;
    st.stuck       = stuck_r;
    st.overflow    = (next_val > (KEY_W+4)'(VALUE_MAX));
    st.below_min   = (count_r < COUNT_W'(mc));
    st.fill_zero   = (fill_r == '0);
    st.fill_full   = (fill_r == FILL_W'(HELD_DEPTH));
    st.ptr_at_last = (FILL_W'(ptr_r) == fill_r - 1'b1);
    st.match       = (held_at_ptr == acc_r);
    st.mark_at_ptr = held_mark_r[ptr_r];
    st.marks_below = |(held_mark_r & below_mask);
    st.marks_any   = |(held_mark_r & fill_mask);
    st.lz_zero     = (lz_r == '0);
    st.lz_hold     = (lz_r == 4'd2) || (lz_r == 4'd4);
    st.emit_ok     = emit_ok;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (cmd.load_in) pulse_r <= in_pulse_count;
  end

  // Mode and sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_mode_r <= 1'b0;
      stuck_r     <= 1'b0;
      count_r     <= '0;
      acc_r       <= '0;
      fill_r      <= '0;
    end else begin
      if (cmd.set_num_mode) code_mode_r <= 1'b0;
      if (cmd.enter_code) begin
        code_mode_r <= 1'b1;
        stuck_r     <= 1'b0;
        count_r     <= '0;
        acc_r       <= '0;
        fill_r      <= '0;
      end
      if (cmd.accum) begin
        if (st.overflow) begin
          stuck_r <= 1'b1;
        end else begin
          acc_r <= next_val[KEY_W-1:0];
          if (count_r != COUNT_MAX) count_r <= count_r + 1'b1;
        end
      end
      if (cmd.clear_seq) begin
        count_r <= '0;
        acc_r   <= '0;
      end
      if (cmd.remove) fill_r <= fill_r - 1'b1;
      if (cmd.append) fill_r <= fill_r + 1'b1;
    end
  end

  // Walk pointer and leading-zero count
  always_ff @(posedge clk) begin
    if (cmd.latch_lz) lz_r <= count_r - COUNT_W'(mc);
    if (cmd.ptr_zero)     ptr_r <= '0;
    else if (cmd.ptr_inc) ptr_r <= ptr_r + 1'b1;
    else if (cmd.ptr_dec) ptr_r <= ptr_r - 1'b1;
    else if (cmd.ptr_top) ptr_r <= IDX_W'(fill_r - 1'b1);
  end

  // Held table: removal closes the gap, append writes at the fill point
  always_ff @(posedge clk) begin
    if (cmd.remove) begin
      for (int k = 0; k < HELD_DEPTH - 1; k++) begin
        if (k >= int'(ptr_r)) begin
          held_val_r[k]  <= held_val_r[k+1];
          held_mark_r[k] <= held_mark_r[k+1];
        end
      end
    end
    if (cmd.append) begin
      held_val_r[fill_r[IDX_W-1:0]]  <= acc_r;
      held_mark_r[fill_r[IDX_W-1:0]] <= (lz_r == 4'd2);
    end
  end

  // Result key select
  always_comb begin
    case (cmd.emit_key)
      KSEL_ASCII: emit_key = ASCII_ZERO + KEY_W'(digit);
      KSEL_ACC:   emit_key = acc_r;
      KSEL_HELD:  emit_key = held_at_ptr;
      KSEL_ZERO:  emit_key = '0;
      default:    emit_key = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && emit_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && emit_ok) begin
      out_action_r <= cmd.emit_act;
      out_key_r    <= emit_key;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_key    = out_key_r;
  assign out_last   = out_last_r;

endmodule

### sv/rotary_dial_key_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_dial_key_encoder_top
// Turns finished dial pulse counts into key type / press / release actions,
// with a number mode (ASCII digits) and a code mode (decimal key values with
// short and plain holds kept in an eight-entry table).
// ----------------------------------------------------------------------------
//  channel | ports                               | dir | handshake
//  input   | in_pulse_count                      | in  | in_valid / in_ready
//  result  | out_action, out_key, out_last       | out | out_valid / out_ready
//
//  One dial turn at a time. The held-table search visits one table entry per
//  cycle; the short-hold release walk does too, but stalls at a marked entry
//  until the output register can take its release.
//  Each result waits in the output register; a stalled out_ready holds the
//  sequencer. Reset (rst_n low, synchronous) leaves number mode, empty table.
// ----------------------------------------------------------------------------
module rotary_dial_key_encoder_top
  import rdke_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PULSE_W-1:0] in_pulse_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_action,
  output logic [KEY_W-1:0]   out_key,
  output logic               out_last
);

  cmd_t    cmd;
  status_t st;

  rdke_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rdke_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_pulse_count (in_pulse_count),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_key        (out_key),
    .out_last       (out_last)
  );

  // A new turn is never taken while the previous one is in progress
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // A hold is never appended to a full table
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !st.fill_full)
    else $error("append with held table full");

  // Removal only from a non-empty table
  a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |-> !st.fill_zero)
    else $error("remove from empty held table");

  // Nothing is emitted while waiting for input
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.emit)
    else $error("result emitted while idle");

endmodule
